// ===== hw/rtl/lrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared constants, types and arithmetic helpers for the listener-relative
// direction pipeline.
// ----------------------------------------------------------------------------
package lrd_pkg;

    // Default parameter values for the top level.
    localparam int COORD_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Internal datapath widths.
    // Legs are normalised to at most 2^38 before the rotations, so the
    // rotation datapath width does not depend on the coordinate width.
    localparam int CORDIC_W   = 43;
    localparam int ANG_W      = 24;
    localparam int GS_W       = 40;
    localparam int SQ_IN_W    = 17;
    localparam int SQ_W       = 37;
    localparam int SQ_STEPS   = 18;
    localparam int AZ_W       = 18;
    localparam int ANG_OUT_W  = 14;
    localparam int TAB_LEN    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int WIDE_CMP_W = 33;
    localparam int PRESHIFT_BASE = 38;

    // Gain of the rotation chain, Q30.
    localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

    // Angle constants: fine units are 1/32768 degree, output units 1/128.
    localparam logic signed [ANG_W-1:0] QUARTER_FINE = 24'sd2949120;
    localparam logic signed [AZ_W-1:0]  DEG90        = 18'sd11520;
    localparam logic signed [AZ_W-1:0]  DEG180       = 18'sd23040;
    localparam logic signed [AZ_W-1:0]  DEG360       = 18'sd46080;
    localparam logic [ANG_OUT_W-1:0]    QUARTER_OUT  = 14'd11520;

    // Distance limits in Q.4 units.
    localparam logic [16:0] DIST_MIN = 17'd16;
    localparam logic [16:0] DIST_MAX = 17'h1FFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LISTENER_X = 2'd0,
        REG_LISTENER_Y = 2'd1,
        REG_LISTENER_Z = 2'd2,
        REG_HEADING    = 2'd3
    } reg_idx_t;

    // Rounded arctangent table in 1/32768 degree.
    localparam logic signed [ANG_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473,
        24'sd117189,  24'sd58652,  24'sd29333,  24'sd14667,
        24'sd7334,    24'sd3667,   24'sd1833,   24'sd917,
        24'sd458,     24'sd229,    24'sd115,    24'sd57,
        24'sd29,      24'sd14,     24'sd7,      24'sd4,
        24'sd2,       24'sd1,      24'sd0,      24'sd0
    };

    // One rotation vector with its angle accumulator.
    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANG_W-1:0]    z;
    } cv_t;

    // Digit-by-digit square root state.
    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } sq_t;

    // Sign, zero and range flags of the differences.
    typedef struct packed {
        logic nx;
        logic ny;
        logic nz;
        logic zx;
        logic zy;
        logic zz;
        logic sat;
    } side_t;

    // First rotation phase: horizontal plane and x/z plane.
    typedef struct packed {
        cv_t             h;
        cv_t             m;
        logic [GS_W-1:0] gay;
        logic [GS_W-1:0] gaz;
        sq_t             sq;
        side_t           sd;
    } p1_t;

    // Second rotation phase: elevation and zenith.
    typedef struct packed {
        cv_t                    e;
        cv_t                    n;
        logic signed [AZ_W-1:0] azp;
        sq_t                    sq;
        side_t                  sd;
    } p2_t;

    // One vectoring rotation step; the shift amount is fixed per stage.
    function automatic cv_t cordic_step(cv_t c, int i);
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        cv_t res;
        xs = c.x >>> i;
        ys = c.y >>> i;
        res = c;
        if (!c.y[CORDIC_W-1])
        begin
            res.x = c.x + ys;
            res.y = c.y - xs;
            res.z = c.z + ATAN_TAB[i];
        end
        else
        begin
            res.x = c.x - ys;
            res.y = c.y + xs;
            res.z = c.z - ATAN_TAB[i];
        end
        return res;
    endfunction

    // Clamp an accumulated angle to a quarter turn and round to 1/128 degree.
    function automatic logic [ANG_OUT_W-1:0] ang_round(logic signed [ANG_W-1:0] z);
        logic [ANG_W-1:0] s;
        logic [ANG_OUT_W-1:0] res;
        s = '0;
        if (z[ANG_W-1])
        begin
            res = '0;
        end
        else if (z > QUARTER_FINE)
        begin
            res = QUARTER_OUT;
        end
        else
        begin
            s   = z + 24'd128;
            res = s[21:8];
        end
        return res;
    endfunction

    // One restoring square-root step; step k works on bit weight 4^(17-k).
    function automatic sq_t sq_step(sq_t s, int k);
        logic [SQ_W-1:0] b;
        logic [SQ_W-1:0] t;
        sq_t res;
        b = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
        t = s.r + b;
        res = s;
        if (s.v >= t)
        begin
            res.v = s.v - t;
            res.r = (s.r >> 1) + b;
        end
        else
        begin
            res.r = s.r >> 1;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/listener_relative_direction_top.sv =====
// ----------------------------------------------------------------------------
// listener_relative_direction_top
// Direction (azimuth, elevation, zenith) and distance of a sound source as
// seen from a listener with a programmable position and heading.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Word
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | source_x, source_y, source_z
//  out      | out_valid / out_stall| azimuth, elevation, zenith, distance
//  cfg      | cfg_write            | cfg_index, cfg_data
//
//  One word is accepted per cycle while in_stall is low.
//  The pipeline holds two rotation phases of CORDIC_STAGES stages each,
//  with the square root spread over the same stages.
//  Reset clears the listener registers and all valid bits; no clearing pass.
//  A skid register behind the output lets one more word leave the pipeline
//  while the output is stalled; the pipeline freezes only when it is full.
// ----------------------------------------------------------------------------
module listener_relative_direction_top
#(
    parameter int COORD_WIDTH   = lrd_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = lrd_pkg::CORDIC_STAGES_DEF,
    localparam int CFG_W = (COORD_WIDTH > 16) ? COORD_WIDTH : 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_WIDTH-1:0]  source_x,
    input  logic signed [COORD_WIDTH-1:0]  source_y,
    input  logic signed [COORD_WIDTH-1:0]  source_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [15:0]             azimuth,
    output logic signed [14:0]             elevation,
    output logic signed [14:0]             zenith,
    output logic [16:0]                    distance
);

    import lrd_pkg::*;

    localparam int CW       = COORD_WIDTH;
    localparam int DW       = COORD_WIDTH + 1;
    localparam int N        = CORDIC_STAGES;
    localparam int TOTAL    = 2 * CORDIC_STAGES;
    localparam int L        = 2 * CORDIC_STAGES + 5;
    localparam int PRESHIFT = PRESHIFT_BASE - COORD_WIDTH;
    localparam int GSHIFT   = COORD_WIDTH - 8;
    localparam int PW       = COORD_WIDTH + 32;

    // Configuration registers.
    logic signed [CW-1:0] listener_x_reg;
    logic signed [CW-1:0] listener_y_reg;
    logic signed [CW-1:0] listener_z_reg;
    logic signed [15:0]   heading_reg;

    // Pipeline control.
    logic         adv;
    logic [L-1:0] vld_reg;

    // Front stages.
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic [DW-1:0]        s2_ax_reg, s2_ay_reg, s2_az_reg;
    side_t                s2_sd_reg;
    logic [DW-1:0]        s3_ax_reg, s3_ay_reg, s3_az_reg;
    logic [GS_W-1:0]      s3_gay_reg, s3_gaz_reg;
    logic [2*SQ_IN_W-1:0] s3_sqx_reg, s3_sqy_reg, s3_sqz_reg;
    side_t                s3_sd_reg;
    p1_t                  s4_reg;

    // Rotation phases.
    p1_t p1_reg [0:N-1];
    p1_t p1_in  [0:N-1];
    p2_t bd_reg;
    p2_t p2_reg [0:N-1];
    p2_t p2_in  [0:N-1];

    // Front stage combinational values.
    logic [DW-1:0]        ax_c, ay_c, az_c;
    logic [PW-1:0]        pay, paz;
    logic [SQ_IN_W-1:0]   cx, cy, cz;
    logic                 sat_c;
    side_t                sd3_c;
    p1_t                  s4_next;
    p2_t                  bd_next;
    logic [ANG_OUT_W-1:0] th;
    logic signed [AZ_W-1:0] azp_c;

    // Output side.
    logic                   fin_vld;
    logic signed [AZ_W-1:0] az_sub;
    logic signed [AZ_W-1:0] az_wrap;
    logic [ANG_OUT_W-1:0]   el_ang, zn_ang;
    logic signed [15:0]     fin_az;
    logic signed [14:0]     fin_el, fin_zn;
    logic [16:0]            fin_ds;
    logic                   out_vld_reg, sk_vld_reg;
    logic signed [15:0]     out_az_reg, sk_az_reg;
    logic signed [14:0]     out_el_reg, sk_el_reg, out_zn_reg, sk_zn_reg;
    logic [16:0]            out_ds_reg, sk_ds_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listener_x_reg <= '0;
            listener_y_reg <= '0;
            listener_z_reg <= '0;
            heading_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LISTENER_X: listener_x_reg <= cfg_data[CW-1:0];
                REG_LISTENER_Y: listener_y_reg <= cfg_data[CW-1:0];
                REG_LISTENER_Z: listener_z_reg <= cfg_data[CW-1:0];
                REG_HEADING:    heading_reg    <= cfg_data[15:0];
            endcase
        end
    end

    // The pipeline moves whenever the skid register is free.
    assign adv      = !sk_vld_reg;
    assign in_stall = !adv;

    // Valid bits travel with the words.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[L-2:0], in_valid};
        end
    end

    // Stage one: differences to the listener.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg <= {source_x[CW-1], source_x} - {listener_x_reg[CW-1], listener_x_reg};
            s1_dy_reg <= {source_y[CW-1], source_y} - {listener_y_reg[CW-1], listener_y_reg};
            s1_dz_reg <= {source_z[CW-1], source_z} - {listener_z_reg[CW-1], listener_z_reg};
        end
    end

    // Stage two: magnitudes and flags.
    assign ax_c = s1_dx_reg[DW-1] ? DW'(-s1_dx_reg) : DW'(s1_dx_reg);
    assign ay_c = s1_dy_reg[DW-1] ? DW'(-s1_dy_reg) : DW'(s1_dy_reg);
    assign az_c = s1_dz_reg[DW-1] ? DW'(-s1_dz_reg) : DW'(s1_dz_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ax_reg     <= ax_c;
            s2_ay_reg     <= ay_c;
            s2_az_reg     <= az_c;
            s2_sd_reg.nx  <= s1_dx_reg[DW-1];
            s2_sd_reg.ny  <= s1_dy_reg[DW-1];
            s2_sd_reg.nz  <= s1_dz_reg[DW-1];
            s2_sd_reg.zx  <= (s1_dx_reg == '0);
            s2_sd_reg.zy  <= (s1_dy_reg == '0);
            s2_sd_reg.zz  <= (s1_dz_reg == '0);
            s2_sd_reg.sat <= 1'b0;
        end
    end

    // Stage three: gain-scaled legs and squares for the distance.
    assign pay   = PW'(s2_ay_reg) * PW'(GAIN_Q30);
    assign paz   = PW'(s2_az_reg) * PW'(GAIN_Q30);
    assign sat_c = (WIDE_CMP_W'(s2_ax_reg) > WIDE_CMP_W'(DIST_MAX))
                || (WIDE_CMP_W'(s2_ay_reg) > WIDE_CMP_W'(DIST_MAX))
                || (WIDE_CMP_W'(s2_az_reg) > WIDE_CMP_W'(DIST_MAX));
    assign cx    = sat_c ? '0 : SQ_IN_W'(s2_ax_reg);
    assign cy    = sat_c ? '0 : SQ_IN_W'(s2_ay_reg);
    assign cz    = sat_c ? '0 : SQ_IN_W'(s2_az_reg);

    // Flags handed on with the range flag filled in.
    always_comb
    begin
        sd3_c     = s2_sd_reg;
        sd3_c.sat = sat_c;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ax_reg     <= s2_ax_reg;
            s3_ay_reg     <= s2_ay_reg;
            s3_az_reg     <= s2_az_reg;
            s3_gay_reg    <= GS_W'(pay >> GSHIFT);
            s3_gaz_reg    <= GS_W'(paz >> GSHIFT);
            s3_sqx_reg    <= cx * cx;
            s3_sqy_reg    <= cy * cy;
            s3_sqz_reg    <= cz * cz;
            s3_sd_reg     <= sd3_c;
        end
    end

    // Stage four: load the rotation vectors and the square-root operand.
    always_comb
    begin
        s4_next.h.x  = $signed(CORDIC_W'(s3_ay_reg) << PRESHIFT);
        s4_next.h.y  = $signed(CORDIC_W'(s3_ax_reg) << PRESHIFT);
        s4_next.h.z  = '0;
        s4_next.m.x  = $signed(CORDIC_W'(s3_ax_reg) << PRESHIFT);
        s4_next.m.y  = $signed(CORDIC_W'(s3_az_reg) << PRESHIFT);
        s4_next.m.z  = '0;
        s4_next.gay  = s3_gay_reg;
        s4_next.gaz  = s3_gaz_reg;
        s4_next.sq.v = SQ_W'(s3_sqx_reg) + SQ_W'(s3_sqy_reg) + SQ_W'(s3_sqz_reg);
        s4_next.sq.r = '0;
        s4_next.sd   = s3_sd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg <= s4_next;
        end
    end

    // First rotation phase: one step per stage on both vectors.
    for (genvar j = 0; j < N; j++)
    begin : g_p1
        p1_t nxt;

        if (j == 0)
        begin : g_first
            assign p1_in[j] = s4_reg;
        end
        else
        begin : g_rest
            assign p1_in[j] = p1_reg[j-1];
        end

        always_comb
        begin
            nxt   = p1_in[j];
            nxt.h = cordic_step(p1_in[j].h, j);
            nxt.m = cordic_step(p1_in[j].m, j);
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                if (((k * TOTAL) / SQ_STEPS) == j)
                begin
                    nxt.sq = sq_step(nxt.sq, k);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p1_reg[j] <= nxt;
            end
        end
    end

    // Phase boundary: horizontal bearing with its axis cases, and the
    // magnitudes handed to the second phase.
    assign th = ang_round(p1_reg[N-1].h.z);

    always_comb
    begin
        priority if (p1_reg[N-1].sd.zx)
        begin
            azp_c = p1_reg[N-1].sd.ny ? DEG180 : '0;
        end
        else if (p1_reg[N-1].sd.zy)
        begin
            azp_c = p1_reg[N-1].sd.nx ? -DEG90 : DEG90;
        end
        else
        begin
            azp_c = $signed(AZ_W'(th));
            if (p1_reg[N-1].sd.ny)
            begin
                azp_c = DEG180 - azp_c;
            end
            if (p1_reg[N-1].sd.nx)
            begin
                azp_c = -azp_c;
            end
        end
    end

    always_comb
    begin
        bd_next.e.x = p1_reg[N-1].h.x;
        bd_next.e.y = $signed(CORDIC_W'(p1_reg[N-1].gaz));
        bd_next.e.z = '0;
        bd_next.n.x = p1_reg[N-1].m.x;
        bd_next.n.y = $signed(CORDIC_W'(p1_reg[N-1].gay));
        bd_next.n.z = '0;
        bd_next.azp = azp_c;
        bd_next.sq  = p1_reg[N-1].sq;
        bd_next.sd  = p1_reg[N-1].sd;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bd_reg <= bd_next;
        end
    end

    // Second rotation phase: elevation and zenith angles.
    for (genvar j = 0; j < N; j++)
    begin : g_p2
        p2_t nxt;

        if (j == 0)
        begin : g_first
            assign p2_in[j] = bd_reg;
        end
        else
        begin : g_rest
            assign p2_in[j] = p2_reg[j-1];
        end

        always_comb
        begin
            nxt   = p2_in[j];
            nxt.e = cordic_step(p2_in[j].e, j);
            nxt.n = cordic_step(p2_in[j].n, j);
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                if (((k * TOTAL) / SQ_STEPS) == (N + j))
                begin
                    nxt.sq = sq_step(nxt.sq, k);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p2_reg[j] <= nxt;
            end
        end
    end

    // Final stage: heading, wrap, signs, special cases and distance limits.
    assign fin_vld = vld_reg[L-1];
    assign az_sub  = p2_reg[N-1].azp - {{(AZ_W-16){heading_reg[15]}}, heading_reg};
    assign el_ang  = ang_round(p2_reg[N-1].e.z);
    assign zn_ang  = ang_round(p2_reg[N-1].n.z);

    always_comb
    begin
        priority if (az_sub > DEG180)
        begin
            az_wrap = az_sub - DEG360;
        end
        else if (az_sub <= -DEG180)
        begin
            az_wrap = az_sub + DEG360;
        end
        else
        begin
            az_wrap = az_sub;
        end
        fin_az = az_wrap[15:0];
    end

    always_comb
    begin
        priority if (p2_reg[N-1].sd.zz)
        begin
            fin_el = '0;
        end
        else if (p2_reg[N-1].sd.zx && p2_reg[N-1].sd.zy)
        begin
            fin_el = p2_reg[N-1].sd.nz ? -15'sd11520 : 15'sd11520;
        end
        else
        begin
            fin_el = p2_reg[N-1].sd.nz ? -$signed(15'(el_ang)) : $signed(15'(el_ang));
        end
    end

    always_comb
    begin
        priority if (p2_reg[N-1].sd.zx && p2_reg[N-1].sd.zy && p2_reg[N-1].sd.zz)
        begin
            fin_zn = '0;
        end
        else if (p2_reg[N-1].sd.zx && p2_reg[N-1].sd.zz)
        begin
            fin_zn = p2_reg[N-1].sd.ny ? -15'sd11520 : 15'sd11520;
        end
        else
        begin
            fin_zn = p2_reg[N-1].sd.ny ? -$signed(15'(zn_ang)) : $signed(15'(zn_ang));
        end
    end

    always_comb
    begin
        priority if (p2_reg[N-1].sd.sat)
        begin
            fin_ds = DIST_MAX;
        end
        else if (p2_reg[N-1].sq.r < SQ_W'(DIST_MIN))
        begin
            fin_ds = DIST_MIN;
        end
        else if (p2_reg[N-1].sq.r > SQ_W'(DIST_MAX))
        begin
            fin_ds = DIST_MAX;
        end
        else
        begin
            fin_ds = p2_reg[N-1].sq.r[16:0];
        end
    end

    // Output register and skid register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            sk_vld_reg  <= 1'b0;
        end
        else if (sk_vld_reg)
        begin
            if (!out_stall)
            begin
                sk_vld_reg <= 1'b0;
            end
        end
        else if (fin_vld)
        begin
            if (out_vld_reg && out_stall)
            begin
                sk_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Output and skid words.
    always_ff @(posedge clk)
    begin
        if (sk_vld_reg)
        begin
            if (!out_stall)
            begin
                out_az_reg <= sk_az_reg;
                out_el_reg <= sk_el_reg;
                out_zn_reg <= sk_zn_reg;
                out_ds_reg <= sk_ds_reg;
            end
        end
        else if (fin_vld)
        begin
            if (out_vld_reg && out_stall)
            begin
                sk_az_reg <= fin_az;
                sk_el_reg <= fin_el;
                sk_zn_reg <= fin_zn;
                sk_ds_reg <= fin_ds;
            end
            else
            begin
                out_az_reg <= fin_az;
                out_el_reg <= fin_el;
                out_zn_reg <= fin_zn;
                out_ds_reg <= fin_ds;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign azimuth   = out_az_reg;
    assign elevation = out_el_reg;
    assign zenith    = out_zn_reg;
    assign distance  = out_ds_reg;

`ifndef SYNTHESIS
    // The skid register only fills behind a held output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        sk_vld_reg |-> out_vld_reg)
        else $error("skid word present without an output word");

    // A word in the skid register moves out as soon as the stall drops.
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (sk_vld_reg && !out_stall) |=> (out_vld_reg && !sk_vld_reg))
        else $error("skid word not moved to the output");

    // Distance never falls below one unit.
    a_dist_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_ds_reg >= DIST_MIN))
        else $error("distance below one unit");

    // Azimuth stays within a half turn either way, in a half-open range.
    a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((out_az_reg > -16'sd23040) && (out_az_reg <= 16'sd23040)))
        else $error("azimuth out of range");

    // Elevation stays within a quarter turn either way.
    a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ((out_el_reg >= -15'sd11520) && (out_el_reg <= 15'sd11520)))
        else $error("elevation out of range");
`endif

endmodule
